FILE: design/windowed_offset_validator_unit_defines.svh
// Assertion macros used by the validator design file.
`ifndef WINDOWED_OFFSET_VALIDATOR_UNIT_DEFINES_SVH
`define WINDOWED_OFFSET_VALIDATOR_UNIT_DEFINES_SVH

`ifndef SYNTH
`define WOVU_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define WOVU_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define WOVU_ASSERT(label, clk, rst, prop)
`define WOVU_ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

FILE: design/wovu_pkg.sv
package wovu_pkg;

   localparam int WINDOW_DEFAULT    = 8;
   localparam int SAMPLE_W          = 16;
   localparam int LIMIT_W           = 8;
   localparam int OFFSET_OUT_W      = 19;
   localparam int REQ_DATA_W        = 16;
   localparam int RSP_DATA_W        = 24;
   localparam int CSR_ADDR_W        = 1;
   localparam int DEV_LIMIT_RESET   = 4;
   localparam int DRIFT_LIMIT_RESET = 4;
   localparam int OUT_DEPTH         = 8;
   localparam int OUT_PTR_W         = $clog2(OUT_DEPTH);

   typedef enum logic [0:0] {
      CMD_ADD   = 1'b0,
      CMD_CLEAR = 1'b1
   } command_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_DEV_LIMIT   = 1'b0,
      CSR_DRIFT_LIMIT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic valid;
      logic clear;
      logic full;
   } stage_ctl_type;

   typedef struct packed {
      logic                    window_full;
      logic                    offset_updated;
      logic [OFFSET_OUT_W-1:0] offset_x8;
   } result_type;

   localparam int RESULT_W = $bits(result_type);

endpackage

FILE: design/windowed_offset_validator_unit.sv
// Moving-window offset validator. Each add beat stores its sample in a ring of WINDOW entries
// held in a registered read-first memory and updates running sums of the samples and
// their squares. Once the ring is full, the window is accepted when WINDOW*sumsq - sum^2 is at
// most WINDOW^2*dev_limit^2, and its sum (the mean times WINDOW) replaces the stored offset when
// no offset is stored yet or when it lies within WINDOW*drift_limit of it. A clear beat empties
// the ring and the fill count and keeps the offset. Every request beat yields exactly one
// response beat. The block takes one request beat per clock while req_tready is high; the
// response passes the ring read at the accepting edge, then sum update, square-sum update,
// scaling, and compare with the queue write, and an eight-entry output queue lets requests
// keep flowing while responses are held back, until its credits run out.
`include "windowed_offset_validator_unit_defines.svh"

module windowed_offset_validator_unit
   import wovu_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [15:0] sample
   input  logic                  req_tuser,   // [0] command
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [18:0] offset_x8, [19] offset_updated,
                                              // [20] window_full, [23:21] zero
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [LIMIT_W-1:0]    csr_wdata
);

   localparam int SLOT_W = $clog2(WINDOW);
   localparam int FILL_W = $clog2(WINDOW + 1);
   localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
   localparam int SQ_W   = 2 * SAMPLE_W + $clog2(WINDOW);
   localparam int CMP_W  = 2 * SUM_W;
   localparam int CNT_W  = $clog2(OUT_DEPTH + 1);
   localparam logic [CMP_W-1:0] LIM_RESET =
      CMP_W'(WINDOW * WINDOW * DEV_LIMIT_RESET * DEV_LIMIT_RESET);
   localparam logic [SUM_W-1:0] DRIFT_RESET = SUM_W'(WINDOW * DRIFT_LIMIT_RESET);

   logic req_acc;
   logic req_clear;
   logic rsp_acc;

   assign req_acc   = req_tvalid && req_tready;
   assign req_clear = (command_type'(req_tuser) == CMD_CLEAR);
   assign rsp_acc   = rsp_tvalid && rsp_tready;

   // Configuration registers and their scaled forms.
   logic [LIMIT_W-1:0]   dev_ff, drift_ff;
   logic [2*LIMIT_W-1:0] dev_sq_ff;
   logic [CMP_W-1:0]     lim_ff;
   logic [SUM_W-1:0]     drift_lim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_ff       <= LIMIT_W'(DEV_LIMIT_RESET);
         drift_ff     <= LIMIT_W'(DRIFT_LIMIT_RESET);
         dev_sq_ff    <= (2*LIMIT_W)'(DEV_LIMIT_RESET * DEV_LIMIT_RESET);
         lim_ff       <= LIM_RESET;
         drift_lim_ff <= DRIFT_RESET;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_addr))
               CSR_DEV_LIMIT:   dev_ff   <= csr_wdata;
               CSR_DRIFT_LIMIT: drift_ff <= csr_wdata;
               default: ;
            endcase
         end
         dev_sq_ff    <= (2*LIMIT_W)'(dev_ff) * (2*LIMIT_W)'(dev_ff);
         lim_ff       <= CMP_W'(dev_sq_ff) * CMP_W'(WINDOW * WINDOW);
         drift_lim_ff <= SUM_W'(drift_ff) * SUM_W'(WINDOW);
      end
   end

   // Ring memory, slot pointer and fill count.
   logic [SAMPLE_W-1:0] ring_mem [WINDOW];
   logic [WINDOW-1:0]   ring_vld_ff;
   logic [SAMPLE_W-1:0] ring_rd_ff;
   logic                ring_rd_vld_ff;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;

   always_ff @(posedge clock) begin
      if (req_acc && !req_clear) begin
         ring_rd_ff        <= ring_mem[slot_ff];
         ring_mem[slot_ff] <= req_tdata[SAMPLE_W-1:0];
      end
   end

   always_comb begin
      slot_in = slot_ff;
      fill_in = fill_ff;
      if (req_acc) begin
         if (req_clear) begin
            slot_in = '0;
            fill_in = '0;
         end else begin
            slot_in = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
            if (fill_ff != FILL_W'(WINDOW)) begin
               fill_in = fill_ff + 1'b1;
            end
         end
      end
   end

   stage_ctl_type s1_ff, s2_ff, s3_ff, s4_ff;
   logic [SAMPLE_W-1:0] s1_sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_vld_ff    <= '0;
         ring_rd_vld_ff <= 1'b0;
         slot_ff        <= '0;
         fill_ff        <= '0;
         s1_ff          <= '0;
      end else begin
         slot_ff <= slot_in;
         fill_ff <= fill_in;
         s1_ff   <= '{valid: req_acc, clear: req_clear,
                      full: (fill_in == FILL_W'(WINDOW))};
         if (req_acc) begin
            if (req_clear) begin
               ring_vld_ff <= '0;
            end else begin
               ring_rd_vld_ff       <= ring_vld_ff[slot_ff];
               ring_vld_ff[slot_ff] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_sample_ff <= req_tdata[SAMPLE_W-1:0];
   end

   // Stage 1: running sum and both squares.
   logic [SAMPLE_W-1:0]   old_sample;
   logic [SUM_W-1:0]      sum_ff;
   logic [2*SAMPLE_W-1:0] old_sq_ff, new_sq_ff;

   assign old_sample = ring_rd_vld_ff ? ring_rd_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         s2_ff  <= '0;
      end else begin
         s2_ff <= s1_ff;
         if (s1_ff.valid) begin
            if (s1_ff.clear) begin
               sum_ff <= '0;
            end else begin
               sum_ff <= sum_ff - SUM_W'(old_sample) + SUM_W'(s1_sample_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      old_sq_ff <= (2*SAMPLE_W)'(old_sample) * (2*SAMPLE_W)'(old_sample);
      new_sq_ff <= (2*SAMPLE_W)'(s1_sample_ff) * (2*SAMPLE_W)'(s1_sample_ff);
   end

   // Stage 2: square sum and squared sum.
   logic [SQ_W-1:0]  sqsum_ff;
   logic [CMP_W-1:0] sum2_ff;
   logic [SUM_W-1:0] s3_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sqsum_ff <= '0;
         s3_ff    <= '0;
      end else begin
         s3_ff <= s2_ff;
         if (s2_ff.valid) begin
            if (s2_ff.clear) begin
               sqsum_ff <= '0;
            end else begin
               sqsum_ff <= sqsum_ff - SQ_W'(old_sq_ff) + SQ_W'(new_sq_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      sum2_ff   <= CMP_W'(sum_ff) * CMP_W'(sum_ff);
      s3_sum_ff <= sum_ff;
   end

   // Stage 3: scale the square sum by the window length.
   logic [CMP_W-1:0] wsq_ff, s4_sum2_ff;
   logic [SUM_W-1:0] s4_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_ff <= '0;
      end else begin
         s4_ff <= s3_ff;
      end
   end

   always_ff @(posedge clock) begin
      wsq_ff     <= CMP_W'(sqsum_ff) * CMP_W'(WINDOW);
      s4_sum2_ff <= sum2_ff;
      s4_sum_ff  <= s3_sum_ff;
   end

   // Stage 4: spread and drift tests, offset update.
   logic [SUM_W-1:0] offset_ff;
   logic [SUM_W-1:0] drift_diff;
   logic             spread_ok, drift_ok, update;
   result_type       result;

   assign spread_ok  = (wsq_ff <= s4_sum2_ff) || ((wsq_ff - s4_sum2_ff) <= lim_ff);
   assign drift_diff = (s4_sum_ff >= offset_ff) ? (s4_sum_ff - offset_ff)
                                                : (offset_ff - s4_sum_ff);
   assign drift_ok   = (offset_ff == '0) || (drift_diff <= drift_lim_ff);
   assign update     = s4_ff.valid && !s4_ff.clear && s4_ff.full && spread_ok && drift_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else if (update) begin
         offset_ff <= s4_sum_ff;
      end
   end

   always_comb begin
      result.window_full    = s4_ff.full && !s4_ff.clear;
      result.offset_updated = update;
      result.offset_x8      = OFFSET_OUT_W'(update ? s4_sum_ff : offset_ff);
   end

   // Output queue with credit count covering beats still in the pipeline.
   result_type         out_mem [OUT_DEPTH];
   logic [OUT_PTR_W:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   credit_ff;

   always_ff @(posedge clock) begin
      if (s4_ff.valid) begin
         out_mem[wr_ptr_ff[OUT_PTR_W-1:0]] <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         credit_ff <= '0;
      end else begin
         if (s4_ff.valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (rsp_acc) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (req_acc && !rsp_acc) begin
            credit_ff <= credit_ff + 1'b1;
         end else if (!req_acc && rsp_acc) begin
            credit_ff <= credit_ff - 1'b1;
         end
      end
   end

   assign req_tready = (credit_ff != CNT_W'(OUT_DEPTH));
   assign rsp_tvalid = (wr_ptr_ff != rd_ptr_ff);
   assign rsp_tdata  = RSP_DATA_W'(out_mem[rd_ptr_ff[OUT_PTR_W-1:0]]);

   `WOVU_ASSERT_NEVER(a_queue_over_credit, clock, reset,
      CNT_W'(wr_ptr_ff - rd_ptr_ff) > credit_ff)
   `WOVU_ASSERT(a_clear_empties, clock, reset,
      (req_acc && req_clear) |=> (fill_ff == '0) && (slot_ff == '0) && (ring_vld_ff == '0))
   `WOVU_ASSERT_NEVER(a_sum_range, clock, reset,
      sum_ff > SUM_W'(WINDOW * ((1 << SAMPLE_W) - 1)))
   `WOVU_ASSERT(a_offset_only_on_update, clock, reset, !update |=> $stable(offset_ff))

endmodule
